// ----- design/pws_pkg.sv -----
// pws_pkg: constants, item types and helpers shared by the PWM waveform sequencer.
// No dependencies; compile first.
`default_nettype none

package pws_pkg;

    localparam int CHANNELS     = 4;
    localparam int SAMPLE_DEPTH = 64;
    localparam int OUT_LANES    = 4;

    localparam int FUNC_W  = 2;
    localparam int CH_W    = 2;
    localparam int DUTY_W  = 15;
    localparam int ADDR_W  = 6;
    localparam int LEN_W   = 7;
    localparam int COUNT_W = 16;
    localparam int MASK_W  = 4;

    localparam int IDX_W = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_SET_DUTY = 2'd1,
        FUNC_START    = 2'd2,
        FUNC_WRITE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_SET_DUTY,
        OP_START,
        OP_WRITE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CH_W-1:0]    channel;
        logic [DUTY_W-1:0]  value;
        logic [IDX_W-1:0]   addr;
        logic [LEN_W-1:0]   length;
        logic [COUNT_W-1:0] loop_count;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    // Zero length plays one sample; anything above the region size plays the region.
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] wide;
        wide = CNT_W'(len);
        if (len == '0)
        begin
            return CNT_W'(1);
        end
        else if (wide > CNT_W'(SAMPLE_DEPTH))
        begin
            return CNT_W'(SAMPLE_DEPTH);
        end
        return wide;
    endfunction

endpackage

`default_nettype wire

// ----- design/pws_if.sv -----
// pws_in_if / pws_out_if: valid-ready channels carrying command items and duty results.
// Depends on pws_pkg for field widths.
`default_nettype none

interface pws_in_if import pws_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [CH_W-1:0]    channel;
    logic [DUTY_W-1:0]  value;
    logic [ADDR_W-1:0]  sample_addr;
    logic [LEN_W-1:0]   length;
    logic [COUNT_W-1:0] loop_count;

    modport source (output valid, func, channel, value, sample_addr, length, loop_count,
                    input ready);
    modport sink   (input valid, func, channel, value, sample_addr, length, loop_count,
                    output ready);
endinterface

interface pws_out_if import pws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [DUTY_W-1:0] duty_d;
    logic [MASK_W-1:0] playing_mask;

    modport source (output valid, duty_a, duty_b, duty_c, duty_d, playing_mask,
                    input ready);
    modport sink   (input valid, duty_a, duty_b, duty_c, duty_d, playing_mask,
                    output ready);
endinterface

`default_nettype wire

// ----- design/pws_front.sv -----
// pws_front: accepts command items and classifies them into queue entries.
// Depends on pws_pkg and pws_in_if.
`default_nettype none

module pws_front import pws_pkg::*; (
    pws_in_if.sink cmd,
    input  logic   full,
    output logic   push,
    output item_t  push_item
);

    logic ch_ok;
    logic addr_ok;
    op_t  op;

    assign ch_ok   = 32'(cmd.channel) < 32'(CHANNELS);
    assign addr_ok = 32'(cmd.sample_addr) < 32'(SAMPLE_DEPTH);

    // Drop commands to absent channels or addresses; they still yield a result.
    always_comb
    begin
        case (func_t'(cmd.func))
            FUNC_TICK:     op = OP_TICK;
            FUNC_SET_DUTY: op = ch_ok ? OP_SET_DUTY : OP_NOP;
            FUNC_START:    op = ch_ok ? OP_START : OP_NOP;
            FUNC_WRITE:    op = (ch_ok && addr_ok) ? OP_WRITE : OP_NOP;
            default:       op = OP_NOP;
        endcase
    end

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;

    always_comb
    begin
        push_item.op         = op;
        push_item.channel    = cmd.channel;
        push_item.value      = cmd.value;
        push_item.addr       = IDX_W'(cmd.sample_addr);
        push_item.length     = cmd.length;
        push_item.loop_count = cmd.loop_count;
    end

endmodule

`default_nettype wire

// ----- design/pws_queue.sv -----
// pws_queue: short FIFO of classified items between front and back.
// Depends on pws_pkg.
`default_nettype none

module pws_queue import pws_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    output logic    full,
    output q_head_t head,
    input  logic    pop
);

    item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QDEPTH);
    assign head.valid = count_reg != '0;
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/pws_back.sv -----
// pws_back: executes queued items against channel state and sample memories,
// then drives the result channel. Depends on pws_pkg and pws_out_if.
`default_nettype none

module pws_back import pws_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  q_head_t head,
    output logic    pop,
    pws_out_if.source result
);

    logic                s1_valid_reg;
    logic [CHANNELS-1:0] s1_load_reg;
    logic [CHANNELS-1:0] s1_set_reg;
    logic [DUTY_W-1:0]   s1_value_reg;
    logic [CHANNELS-1:0] s1_mask_reg;
    logic                out_valid_reg;
    logic [CHANNELS-1:0] out_mask_reg;

    logic                out_adv;
    logic                s1_adv;
    logic                is_tick;
    logic                is_set;
    logic                is_start;
    logic                is_write;
    logic [CHANNELS-1:0] load_next;
    logic [CHANNELS-1:0] set_next;
    logic [CHANNELS-1:0] playing_next;
    logic [DUTY_W-1:0]   duty_vec [CHANNELS];
    logic [DUTY_W-1:0]   lane [OUT_LANES];

    assign out_adv = !out_valid_reg || result.ready;
    assign s1_adv  = s1_valid_reg && out_adv;
    assign pop     = head.valid && (!s1_valid_reg || out_adv);

    assign is_tick  = pop && (head.item.op == OP_TICK);
    assign is_set   = pop && (head.item.op == OP_SET_DUTY);
    assign is_start = pop && (head.item.op == OP_START);
    assign is_write = pop && (head.item.op == OP_WRITE);

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        logic                match;
        logic                tick_c;
        logic [CNT_W-1:0]    inc;
        logic                wrap;
        logic                play_reg, play_next;
        logic [IDX_W-1:0]    idx_reg, idx_next;
        logic [LEN_W-1:0]    len_reg, len_next;
        logic [COUNT_W-1:0]  left_reg, left_next;
        logic [DUTY_W-1:0]   duty_reg, duty_next;
        logic [DUTY_W-1:0]   rd_data_reg;
        logic [DUTY_W-1:0]   mem [SAMPLE_DEPTH];

        assign match  = head.item.channel == CH_W'(c);
        assign tick_c = is_tick && play_reg;
        assign inc    = CNT_W'(idx_reg) + CNT_W'(1);
        assign wrap   = inc >= eff_len(len_reg);

        always_comb
        begin
            play_next = play_reg;
            idx_next  = idx_reg;
            len_next  = len_reg;
            left_next = left_reg;
            if (tick_c)
            begin
                idx_next = wrap ? '0 : inc[IDX_W-1:0];
                // Finite loops count down on wrap and freeze on the last sample.
                if (wrap && left_reg != '0)
                begin
                    left_next = left_reg - COUNT_W'(1);
                    if (left_reg == COUNT_W'(1))
                    begin
                        play_next = 1'b0;
                    end
                end
            end
            else if (is_set && match)
            begin
                play_next = 1'b0;
            end
            else if (is_start && match)
            begin
                play_next = 1'b1;
                len_next  = head.item.length;
                left_next = head.item.loop_count;
            end
        end

        always_comb
        begin
            duty_next = duty_reg;
            if (s1_adv && s1_load_reg[c])
            begin
                duty_next = rd_data_reg;
            end
            else if (s1_adv && s1_set_reg[c])
            begin
                duty_next = s1_value_reg;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                play_reg <= 1'b0;
                idx_reg  <= '0;
                len_reg  <= '0;
                left_reg <= '0;
                duty_reg <= '0;
            end
            else
            begin
                play_reg <= play_next;
                idx_reg  <= idx_next;
                len_reg  <= len_next;
                left_reg <= left_next;
                duty_reg <= duty_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (is_write && match)
            begin
                mem[head.item.addr] <= head.item.value;
            end
            if (tick_c)
            begin
                rd_data_reg <= mem[idx_reg];
            end
        end

        assign load_next[c]    = tick_c;
        assign set_next[c]     = is_set && match;
        assign playing_next[c] = play_next;
        assign duty_vec[c]     = duty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_mask_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                out_mask_reg  <= s1_mask_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_load_reg  <= load_next;
            s1_set_reg   <= set_next;
            s1_value_reg <= head.item.value;
            s1_mask_reg  <= playing_next;
        end
    end

    for (genvar l = 0; l < OUT_LANES; l++)
    begin : g_lane
        if (l < CHANNELS)
        begin : g_used
            assign lane[l] = duty_vec[l];
        end
        else
        begin : g_unused
            assign lane[l] = '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.duty_a       = lane[0];
    assign result.duty_b       = lane[1];
    assign result.duty_c       = lane[2];
    assign result.duty_d       = lane[3];
    assign result.playing_mask = MASK_W'(out_mask_reg);

    a_set_not_playing: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((s1_mask_reg & s1_set_reg) == '0))
        else $error("channel set to constant duty still marked playing");

    a_load_xor_set: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((s1_load_reg & s1_set_reg) == '0))
        else $error("duty both loaded from samples and set constant");

    a_single_set: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(s1_set_reg))
        else $error("constant duty applied to more than one channel");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(s1_mask_reg)
                                         && $stable(s1_load_reg)))
        else $error("execute stage lost its item while the result stalled");

endmodule

`default_nettype wire

// ----- design/pwm_waveform_sequencer.sv -----
// Four-channel PWM duty sequencer: each channel holds a constant duty or replays
// a looped sample table; one result with all duties per command item, one item
// per clock sustained while the result is taken. Results pass the queue entry,
// then execute with the per-channel sample RAM read, which loads the result
// register; the registered read of each channel's single-port sample RAM sets
// the pipeline depth.
// Sample entries must be written before a loop plays them. Depends on pws_pkg,
// pws_if, pws_front, pws_queue and pws_back.
`default_nettype none

module pwm_waveform_sequencer import pws_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pws_in_if.sink    cmd,
    pws_out_if.source result
);

    logic    full;
    logic    push;
    item_t   push_item;
    q_head_t head;
    logic    pop;

    pws_front u_front (
        .cmd       (cmd),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    pws_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .head      (head),
        .pop       (pop)
    );

    pws_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire
